// File: src/kup_pkg.sv
// Package for the row upscaler: widths, register indexes, kernel codes and the
// tap weight tables. No dependencies.
package kup_pkg;

  localparam int MaxFactor = 16;
  localparam int FracBits  = 12;
  localparam int PhaseW    = 4;   // phase index 0..15
  localparam int FactW     = 5;   // factor 1..16
  localparam int WeightW   = 16;  // signed Q2.12 plus headroom
  localparam int AccW      = 22;  // 4 taps of Q2.12 times 8-bit pixel, signed
  localparam int DivBits   = 40;  // dividend bits of the table build division

  localparam logic [0:0] RegScale  = 1'b0;
  localparam logic [0:0] RegKernel = 1'b1;

  typedef enum logic [1:0] {
    KernBox   = 2'd0,
    KernTent  = 2'd1,
    KernBell  = 2'd2,
    KernCubic = 2'd3
  } kern_e;

  // Controller to datapath.
  typedef struct packed {
    logic              load_all;   // first pixel of a row: fill window
    logic              shift;      // shift pixel into newest entry
    logic              rep_shift;  // shift last pixel in again before this emit
    logic              emit;       // compute one output at phase
    logic [PhaseW-1:0] phase;
    logic              run_last;
    logic              row_done;
  } kup_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic busy;  // pipeline or output register holds a word
    logic full;  // cannot take an emit this cycle
  } kup_stat_t;

  // Rounded quotient, ties away from zero, by long division on constants.
  function automatic logic signed [63:0] div_rnd(input logic signed [63:0] num,
                                                 input logic signed [63:0] den);
    logic [63:0] dvd;
    logic [63:0] dvs;
    logic [63:0] rem;
    logic [63:0] q;
    begin
      dvd = 64'((num < 0) ? -num : num);
      dvd = (dvd << 1) + 64'(den);
      dvs = 64'(den) << 1;
      rem = '0;
      q   = '0;
      for (int i = DivBits - 1; i >= 0; i--) begin
        rem = {rem[62:0], dvd[i]};
        if (rem >= dvs) begin
          rem  = rem - dvs;
          q[i] = 1'b1;
        end
      end
      div_rnd = (num < 0) ? -$signed(q) : $signed(q);
    end
  endfunction

  // Exact kernel weight; evaluated only to build the constant tables.
  function automatic logic signed [63:0] weight_calc(input kern_e mode, input int d,
                                                     input int k, input int f);
    logic signed [63:0] one;
    logic signed [63:0] ff;
    logic signed [63:0] s;
    logic signed [63:0] u;
    logic signed [63:0] r;
    begin
      one = 64'sd1 <<< FracBits;
      ff = f;
      s = d * ff - k;
      u = (s < 0) ? -s : s;
      r = 0;
      case (mode)
        KernBox: r = (2 * s >= -ff && 2 * s < ff) ? one : 0;
        KernTent: r = (u <= ff) ? div_rnd((ff - u) * one, ff) : 0;
        KernBell: begin
          if (2 * u <= ff)
            r = div_rnd((3 * ff * ff - 4 * u * u) * one, 4 * ff * ff);
          else if (2 * u <= 3 * ff)
            r = div_rnd((2 * u - 3 * ff) * (2 * u - 3 * ff) * one, 8 * ff * ff);
        end
        default: begin
          if (u < ff)
            r = div_rnd((21 * u * u * u - 36 * u * u * ff + 16 * ff * ff * ff) * one,
                        18 * ff * ff * ff);
          else if (u < 2 * ff)
            r = div_rnd((-7 * u * u * u + 36 * u * u * ff - 60 * u * ff * ff
                         + 32 * ff * ff * ff) * one, 18 * ff * ff * ff);
        end
      endcase
      weight_calc = r;
    end
  endfunction

  // One row holds the four tap weights; one table per kernel, indexed by
  // {factor - 1, phase}.
  typedef logic [3:0][WeightW-1:0] wrow_t;
  typedef wrow_t [MaxFactor*MaxFactor-1:0] wtab_t;

  function automatic wtab_t build_tab(input kern_e mode);
    wtab_t t;
    logic signed [63:0] w;
    begin
      t = '0;
      for (int fi = 0; fi < MaxFactor; fi++)
        for (int k = 0; k < MaxFactor; k++)
          for (int d = 0; d < 4; d++) begin
            w = (k <= fi) ? weight_calc(mode, d - 1, k, fi + 1) : 64'sd0;
            t[fi * MaxFactor + k][d] = w[WeightW-1:0];
          end
      build_tab = t;
    end
  endfunction

  localparam wtab_t WTabBox   = build_tab(KernBox);
  localparam wtab_t WTabTent  = build_tab(KernTent);
  localparam wtab_t WTabBell  = build_tab(KernBell);
  localparam wtab_t WTabCubic = build_tab(KernCubic);

endpackage

// File: src/kup_ctrl.sv
// Controller for the row upscaler: accepts pixels, sequences window updates and
// one output phase per cycle while the datapath is not full. Depends on kup_pkg.
module kup_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                row_end_i,
  input  logic [4:0]          scale_factor_i,
  input  kup_pkg::kup_stat_t  stat_i,
  output kup_pkg::kup_cmd_t   cmd_o,
  output logic                idle_o
);

  typedef enum logic [1:0] {
    StIdle,
    StEmit
  } state_e;

  state_e                      state_q, state_d;
  logic [1:0]                  seen_q, seen_d;
  logic [1:0]                  groups_q, groups_d;  // groups still to emit
  logic                        rowend_q, rowend_d;
  logic [kup_pkg::PhaseW-1:0]  phase_q, phase_d;
  logic [kup_pkg::PhaseW-1:0]  flast;
  logic                        accept;
  logic                        shift_next;          // shift before next group
  logic                        pend_q, pend_d;      // flush group awaits its shift

  always_comb begin
    if (scale_factor_i == 5'd0) flast = '0;
    else if (scale_factor_i > 5'(kup_pkg::MaxFactor))
      flast = kup_pkg::PhaseW'(kup_pkg::MaxFactor - 1);
    else flast = kup_pkg::PhaseW'(scale_factor_i - 5'd1);
  end

  assign in_stall_o = (state_q != StIdle);
  assign accept     = in_valid_i && !in_stall_o;
  assign idle_o     = (state_q == StIdle) && !stat_i.busy;

  always_comb begin
    state_d  = state_q;
    seen_d   = seen_q;
    groups_d = groups_q;
    rowend_d = rowend_q;
    phase_d  = phase_q;
    cmd_o    = '0;
    shift_next = 1'b0;
    case (state_q)
      StIdle: begin
        if (accept) begin
          cmd_o.load_all = (seen_q == 2'd0);
          cmd_o.shift    = (seen_q != 2'd0);
          groups_d = ((seen_q >= 2'd2) ? 2'd1 : 2'd0)
                   + (row_end_i ? ((seen_q == 2'd0) ? 2'd1 : 2'd2) : 2'd0);
          rowend_d = row_end_i;
          phase_d  = '0;
          seen_d   = row_end_i ? 2'd0 : ((seen_q == 2'd3) ? 2'd3 : seen_q + 2'd1);
          if (groups_d != 2'd0) state_d = StEmit;
        end
      end
      StEmit: begin
        // Flush groups on row end start with a shift of the last pixel; the
        // regular group (if any) comes first without one.
        if (!stat_i.full) begin
          cmd_o.emit      = 1'b1;
          cmd_o.rep_shift = pend_q;
          cmd_o.phase     = phase_q;
          if (phase_q == flast) begin
            cmd_o.run_last = (groups_q == 2'd1);
            cmd_o.row_done = (groups_q == 2'd1) && rowend_q;
            phase_d  = '0;
            groups_d = groups_q - 2'd1;
            if (groups_q == 2'd1) state_d = StIdle;
            else shift_next = 1'b1;
          end else begin
            phase_d = phase_q + kup_pkg::PhaseW'(1);
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // A flush group needs the repeat shift before its first phase.
  always_comb begin
    pend_d = pend_q;
    if (accept) pend_d = row_end_i && (seen_q < 2'd2);
    else if (shift_next) pend_d = 1'b1;
    else if (cmd_o.emit && pend_q) pend_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      seen_q   <= 2'd0;
      groups_q <= 2'd0;
      rowend_q <= 1'b0;
      phase_q  <= '0;
      pend_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      seen_q   <= seen_d;
      groups_q <= groups_d;
      rowend_q <= rowend_d;
      phase_q  <= phase_d;
      pend_q   <= pend_d;
    end
  end

endmodule

// File: src/kup_dp.sv
// Datapath for the row upscaler: pixel window, weight lookup, multiply and
// accumulate, round and clamp, output register. Depends on kup_pkg.
module kup_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  kup_pkg::kup_cmd_t  cmd_i,
  input  logic [23:0]        pix_i,
  input  logic [4:0]         scale_factor_i,
  input  logic [1:0]         kernel_mode_i,
  output kup_pkg::kup_stat_t stat_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         red_o,
  output logic [7:0]         green_o,
  output logic [7:0]         blue_o,
  output logic               run_last_o,
  output logic               row_done_o
);

  logic [23:0] win_q [4];
  logic [23:0] win_d [4];
  logic [23:0] last_q;

  logic [kup_pkg::PhaseW-1:0] fidx;
  always_comb begin
    if (scale_factor_i == 5'd0) fidx = '0;
    else if (scale_factor_i > 5'(kup_pkg::MaxFactor))
      fidx = kup_pkg::PhaseW'(kup_pkg::MaxFactor - 1);
    else fidx = kup_pkg::PhaseW'(scale_factor_i - 5'd1);
  end

  always_comb begin
    win_d = win_q;
    if (cmd_i.load_all) begin
      for (int i = 0; i < 4; i++) win_d[i] = pix_i;
    end else if (cmd_i.shift || cmd_i.rep_shift) begin
      win_d[0] = win_q[1];
      win_d[1] = win_q[2];
      win_d[2] = win_q[3];
      win_d[3] = cmd_i.shift ? pix_i : last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) win_q[i] <= '0;
      last_q <= '0;
    end else begin
      win_q <= win_d;
      if (cmd_i.load_all || cmd_i.shift) last_q <= pix_i;
    end
  end

  // Stage 1: weights and window snapshot.
  logic                              s1_v_q;
  kup_pkg::wrow_t                    s1_w_q;
  logic [23:0]                       s1_p_q [4];
  logic                              s1_rl_q, s1_rd_q;
  // Stage 2: accumulate.
  logic                              s2_v_q;
  logic signed [kup_pkg::AccW-1:0]   s2_acc_q [3];
  logic                              s2_rl_q, s2_rd_q;
  // Output register.
  logic                              o_v_q;

  logic adv2, adv1, take;
  assign adv2 = !o_v_q || !out_stall_i;
  assign adv1 = !s2_v_q || adv2;
  assign take = !s1_v_q || adv1;
  assign stat_o.full = !take;
  assign stat_o.busy = s1_v_q || s2_v_q || o_v_q;

  logic [7:0] tidx;
  assign tidx = {fidx, cmd_i.phase};

  kup_pkg::wrow_t wsel;
  always_comb begin
    case (kernel_mode_i)
      kup_pkg::KernBox:  wsel = kup_pkg::WTabBox[tidx];
      kup_pkg::KernTent: wsel = kup_pkg::WTabTent[tidx];
      kup_pkg::KernBell: wsel = kup_pkg::WTabBell[tidx];
      default:           wsel = kup_pkg::WTabCubic[tidx];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      o_v_q  <= 1'b0;
    end else begin
      if (take) s1_v_q <= cmd_i.emit;
      if (adv1) s2_v_q <= s1_v_q;
      if (adv2) o_v_q  <= s2_v_q;
    end
  end

  logic signed [kup_pkg::AccW-1:0] acc [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      acc[c] = '0;
      for (int d = 0; d < 4; d++)
        acc[c] = acc[c] + kup_pkg::AccW'($signed(s1_w_q[d]))
                 * kup_pkg::AccW'($signed({1'b0, s1_p_q[d][16-8*c +: 8]}));
    end
  end

  function automatic logic [7:0] sat(input logic signed [kup_pkg::AccW-1:0] a);
    logic signed [kup_pkg::AccW-1:0] r;
    begin
      r = (a + kup_pkg::AccW'(1 << (kup_pkg::FracBits - 1))) >>> kup_pkg::FracBits;
      if (a < 0) sat = 8'd0;
      else if (r > 255) sat = 8'd255;
      else sat = r[7:0];
    end
  endfunction

  always_ff @(posedge clk_i) begin
    if (take && cmd_i.emit) begin
      s1_w_q  <= wsel;
      s1_p_q  <= win_d;
      s1_rl_q <= cmd_i.run_last;
      s1_rd_q <= cmd_i.row_done;
    end
    if (adv1 && s1_v_q) begin
      s2_acc_q <= acc;
      s2_rl_q  <= s1_rl_q;
      s2_rd_q  <= s1_rd_q;
    end
    if (adv2 && s2_v_q) begin
      red_o      <= sat(s2_acc_q[0]);
      green_o    <= sat(s2_acc_q[1]);
      blue_o     <= sat(s2_acc_q[2]);
      run_last_o <= s2_rl_q;
      row_done_o <= s2_rd_q;
    end
  end

  assign out_valid_o = o_v_q;

endmodule

// File: src/kernel_upscaler_row.sv
// Top level of the horizontal row upscaler: config registers, controller and
// datapath. Depends on kup_pkg, kup_ctrl and kup_dp.
//
// Each source pixel produces f output words (f = scale_factor clamped to
// 1..16), one per cycle unless the output stalls, from a four-pixel window
// with replicated borders; the last pixel of a row also produces one or two
// flush groups. The input is stalled while groups are being emitted, so a new
// pixel is not taken until the controller has issued all pending groups.
// Results leave after three register stages.
module kernel_upscaler_row (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] red_in_i,
  input  logic [7:0] green_in_i,
  input  logic [7:0] blue_in_i,
  input  logic       row_end_in_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] red_out_o,
  output logic [7:0] green_out_o,
  output logic [7:0] blue_out_o,
  output logic       run_last_o,
  output logic       row_done_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [0:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  logic [4:0] scale_q;
  logic [1:0] kern_q;
  kup_pkg::kup_cmd_t  cmd;
  kup_pkg::kup_stat_t stat;
  logic idle;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= 5'd2;
      kern_q  <= kup_pkg::KernBox;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        kup_pkg::RegScale:  scale_q <= cfg_data_i[4:0];
        kup_pkg::RegKernel: kern_q  <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  kup_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .row_end_i(row_end_in_i), .scale_factor_i(scale_q),
    .stat_i(stat), .cmd_o(cmd), .idle_o(idle)
  );

  kup_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd),
    .pix_i({red_in_i, green_in_i, blue_in_i}),
    .scale_factor_i(scale_q), .kernel_mode_i(kern_q),
    .stat_o(stat), .out_valid_o, .out_stall_i,
    .red_o(red_out_o), .green_o(green_out_o), .blue_o(blue_out_o),
    .run_last_o, .row_done_o
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && row_done_o |-> run_last_o)
    else $error("row_done without run_last");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    idle |-> !out_valid_o)
    else $error("idle with pending word");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> !cmd.load_all)
    else $error("emit during window load");

endmodule
